>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SCFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SCFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/scfa_pkg.sv
// Types, constants and codes of the size-class free-list allocator.
package scfa_pkg;

  localparam int unsigned BLOCKS_PER_CLASS_DEF = 1024;
  localparam int unsigned CLASS_COUNT_DEF      = 6;

  localparam int unsigned REG_COUNT  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned BLK_W      = 10;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CLS_W      = 3;

  typedef logic [REG_COUNT-1:0][SIZE_W-1:0] limits_t;

  localparam limits_t LIMIT_RESET = {16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8};

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_NULL      = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DECIDE,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic             hit;
    logic [CLS_W-1:0] idx;
  } class_sel_t;

endpackage

>>> hw/rtl/scfa_class_sel.sv
// Size class lookup: lowest numbered class whose limit covers the size.
module scfa_class_sel #(
  parameter int unsigned CLASS_COUNT = scfa_pkg::CLASS_COUNT_DEF
) (
  input  scfa_pkg::limits_t            limits_i,
  input  logic [scfa_pkg::SIZE_W-1:0]  size_i,
  output scfa_pkg::class_sel_t         sel_o
);
  import scfa_pkg::*;

  // Scan from the top down so the lowest fitting class wins.
  always_comb begin
    sel_o = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (size_i <= limits_i[c]) begin
        sel_o.hit = 1'b1;
        sel_o.idx = CLS_W'(c);
      end
    end
  end

endmodule

>>> hw/rtl/scfa_stack_mem.sv
// Single-port synchronous RAM holding the returned-block stacks of all classes.
module scfa_stack_mem #(
  parameter int unsigned DEPTH = scfa_pkg::CLASS_COUNT_DEF * scfa_pkg::BLOCKS_PER_CLASS_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [scfa_pkg::BLK_W-1:0]  wdata_i,
  output logic [scfa_pkg::BLK_W-1:0]  rdata_o
);
  import scfa_pkg::*;

  logic [BLK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

>>> hw/rtl/size_class_free_list_allocator_unit.sv
// Top level of the segregated size-class free-list allocator.
//
// Requests come in on the s_axis channel: tuser carries kind (bit 0, 0 =
// allocate, 1 = free) and handle_present (bit 1); tdata carries request_size
// [15:0] and block_handle [25:16]. Each request gives exactly one result beat
// on m_axis: tuser is the status code, tdata holds class_index [2:0] and
// block_index [12:3].
// The class limits are written over the cfg port (index 0..5); the port is
// always ready and writes to index 6 or 7 are dropped.
// One request is in flight at a time: accept, decide (class lookup, count
// update, stack RAM read or write), then result load. No new request is
// taken until the result is loaded and the block is back in idle; the
// single-port stack RAM, whose read data is registered, is why the decide
// and load steps are separate.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits. A stalled receiver holds the result
// beat; the block then waits in its load step with s_axis_tready low.
// Reset clears the counts (no returned blocks, every block fresh) and loads
// the default limits 8..256. The stack RAM itself is never cleared: the
// returned counts guarantee only written entries are ever popped.
module size_class_free_list_allocator_unit #(
  parameter int unsigned BLOCKS_PER_CLASS = scfa_pkg::BLOCKS_PER_CLASS_DEF,
  parameter int unsigned CLASS_COUNT      = scfa_pkg::CLASS_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // request_size, block_handle, pad
  input  logic [1:0]                      s_axis_tuser,  // kind, handle_present
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // class_index, block_index, pad
  output logic [scfa_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
  // limit register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scfa_pkg::SIZE_W-1:0]     cfg_data_i
);
  import scfa_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CntW  = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int unsigned Depth = CLASS_COUNT * BLOCKS_PER_CLASS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned IdxW  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  // ---------------- limit registers ----------------
  limits_t limits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= LIMIT_RESET;
    end else if (cfg_valid_i && (32'(cfg_index_i) < REG_COUNT)) begin
      limits_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // ---------------- request capture ----------------
  fsm_e state_q, state_d;

  logic              kind_q;
  logic              present_q;
  logic [SIZE_W-1:0] size_q;
  logic [BLK_W-1:0]  handle_q;

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      kind_q    <= s_axis_tuser[0];
      present_q <= s_axis_tuser[1];
      size_q    <= s_axis_tdata[SIZE_W-1:0];
      handle_q  <= s_axis_tdata[SIZE_W +: BLK_W];
    end
  end

  // ---------------- class lookup ----------------
  class_sel_t sel;

  scfa_class_sel #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_class_sel (
    .limits_i (limits_q),
    .size_i   (size_q),
    .sel_o    (sel)
  );

  // ---------------- per-class counts ----------------
  logic [CntW-1:0] ret_cnt_q   [CLASS_COUNT];
  logic [CntW-1:0] fresh_cnt_q [CLASS_COUNT];

  logic [IdxW-1:0] cls;
  logic [CntW-1:0] ret, fr, ret_dec, fr_dec;
  logic [CntW:0]   used_sum;
  logic            op_pop, op_fresh, op_push;
  status_e         res_status_d;

  assign cls      = sel.idx[IdxW-1:0];
  assign ret      = ret_cnt_q[cls];
  assign fr       = fresh_cnt_q[cls];
  assign ret_dec  = ret - CntW'(1);
  assign fr_dec   = fr - CntW'(1);
  assign used_sum = {1'b0, ret} + {1'b0, fr};

  always_comb begin
    op_pop       = 1'b0;
    op_fresh     = 1'b0;
    op_push      = 1'b0;
    res_status_d = ST_TOO_LARGE;
    if (sel.hit) begin
      if (!kind_q) begin
        if (ret != '0) begin
          op_pop       = 1'b1;
          res_status_d = ST_ALLOCATED;
        end else if (fr != '0) begin
          op_fresh     = 1'b1;
          res_status_d = ST_ALLOCATED;
        end else begin
          res_status_d = ST_EXHAUSTED;
        end
      end else if (!present_q) begin
        res_status_d = ST_NULL;
      end else if (used_sum >= (CntW + 1)'(BLOCKS_PER_CLASS)) begin
        res_status_d = ST_OVERFLOW;
      end else begin
        op_push      = 1'b1;
        res_status_d = ST_FREED;
      end
    end
  end

  logic decide;
  assign decide = (state_q == FSM_DECIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        ret_cnt_q[c]   <= '0;
        fresh_cnt_q[c] <= CntW'(BLOCKS_PER_CLASS);
      end
    end else if (decide) begin
      if (op_pop)   ret_cnt_q[cls]   <= ret_dec;
      if (op_push)  ret_cnt_q[cls]   <= ret + CntW'(1);
      if (op_fresh) fresh_cnt_q[cls] <= fr_dec;
    end
  end

  // ---------------- stack RAM ----------------
  logic [AddrW-1:0] base, mem_addr;
  logic [BLK_W-1:0] mem_rdata;
  logic             mem_en;

  assign base     = AddrW'(cls) * AddrW'(BLOCKS_PER_CLASS);
  assign mem_addr = base + (op_pop ? AddrW'(ret_dec) : AddrW'(ret));
  assign mem_en   = decide && (op_pop || op_push);

  scfa_stack_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (op_push),
    .addr_i  (mem_addr),
    .wdata_i (handle_q),
    .rdata_o (mem_rdata)
  );

  // ---------------- decided result ----------------
  status_e          res_status_q;
  logic [CLS_W-1:0] res_cls_q;
  logic [BLK_W-1:0] res_blk_q;
  logic             res_from_mem_q;

  always_ff @(posedge clk_i) begin
    if (decide) begin
      res_status_q   <= res_status_d;
      res_cls_q      <= sel.idx;
      res_blk_q      <= op_fresh ? BLK_W'(fr_dec) : '0;
      res_from_mem_q <= op_pop;
    end
  end

  // ---------------- sequencer ----------------
  logic out_valid_q;
  logic out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FSM_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = FSM_DECIDE;
      end
      FSM_DECIDE: begin
        state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // ---------------- output register ----------------
  status_e          out_status_q;
  logic [CLS_W-1:0] out_cls_q;
  logic [BLK_W-1:0] out_blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_cls_q    <= res_cls_q;
      out_blk_q    <= res_from_mem_q ? mem_rdata : res_blk_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_blk_q, out_cls_q};

  // ---------------- checks ----------------
  logic counts_ok;
  always_comb begin
    counts_ok = 1'b1;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (({1'b0, ret_cnt_q[c]} + {1'b0, fresh_cnt_q[c]}) > (CntW + 1)'(BLOCKS_PER_CLASS)) begin
        counts_ok = 1'b0;
      end
    end
  end

  logic pop_rd, pop_held;
  assign pop_rd   = mem_en && !op_push;
  assign pop_held = (state_q == FSM_FINISH) && res_from_mem_q;

  `SCFA_ASSERT(a_counts_bounded, counts_ok, "class holds more blocks than it owns")
  `SCFA_ASSERT(a_one_stack_op, !decide || $onehot0({op_pop, op_push, op_fresh}), "two stack ops")
  `SCFA_ASSERT_NEXT(a_pop_then_load, pop_rd, pop_held, "popped data not picked up")

endmodule

>>> test/scfa_outcome_checker.sv
// Checker for the allocator: tracks limits and free lists, predicts every result beat.
module scfa_outcome_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // request_size, block_handle, pad
  input  logic [1:0]                     s_axis_tuser,  // kind, handle_present
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [15:0]                    m_axis_tdata,  // class_index, block_index, pad
  input  logic [scfa_pkg::STATUS_W-1:0]  m_axis_tuser,  // status
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [scfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [scfa_pkg::SIZE_W-1:0]    cfg_data_i,
  output int                             backlog_o,
  output int                             mismatches_o
);
  import scfa_pkg::*;

  localparam int BLOCKS  = BLOCKS_PER_CLASS_DEF;
  localparam int CLASSES = CLASS_COUNT_DEF;

  typedef struct packed {
    status_e          status;
    logic [CLS_W-1:0] cls;
    logic [BLK_W-1:0] blk;
  } outcome_t;

  logic [SIZE_W-1:0] limit_q [REG_COUNT];
  logic [BLK_W-1:0]  returned_blocks [CLASSES][BLOCKS];
  int unsigned       returned_cnt [CLASSES];
  int unsigned       fresh_cnt [CLASSES];
  outcome_t          outcome_q [$];
  outcome_t          want;
  int                mismatch_cnt;

  // Lowest numbered class whose limit covers the size wins; free lists are LIFO.
  function automatic outcome_t resolve_request(input logic is_free,
                                               input logic [SIZE_W-1:0] size,
                                               input logic present,
                                               input logic [BLK_W-1:0] handle);
    outcome_t res;
    int       c;
    int       pick;
    res.status = ST_TOO_LARGE;
    res.cls    = '0;
    res.blk    = '0;
    pick       = -1;
    for (c = CLASSES - 1; c >= 0; c--) begin
      if (size <= limit_q[c]) pick = c;
    end
    if (pick >= 0) begin
      res.cls = CLS_W'(pick);
      if (!is_free) begin
        if (returned_cnt[pick] > 0) begin
          returned_cnt[pick]--;
          res.blk    = returned_blocks[pick][returned_cnt[pick]];
          res.status = ST_ALLOCATED;
        end else if (fresh_cnt[pick] > 0) begin
          fresh_cnt[pick]--;
          res.blk    = BLK_W'(fresh_cnt[pick]);
          res.status = ST_ALLOCATED;
        end else begin
          res.status = ST_EXHAUSTED;
        end
      end else if (!present) begin
        res.status = ST_NULL;
      end else if (returned_cnt[pick] + fresh_cnt[pick] >= BLOCKS) begin
        res.status = ST_OVERFLOW;
      end else begin
        returned_blocks[pick][returned_cnt[pick]] = handle;
        returned_cnt[pick]++;
        res.status = ST_FREED;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) limit_q[i] = LIMIT_RESET[i];
      for (int i = 0; i < CLASSES; i++) begin
        returned_cnt[i] = 0;
        fresh_cnt[i]    = BLOCKS;
      end
      outcome_q.delete();
      mismatch_cnt = 0;
      backlog_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < REG_COUNT)
        limit_q[cfg_index_i] = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        outcome_q = {outcome_q, resolve_request(s_axis_tuser[0], s_axis_tdata[15:0],
                                                s_axis_tuser[1], s_axis_tdata[25:16])};
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result beat: status %0d class %0d block %0d",
                     m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[12:3]);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tuser != want.status || m_axis_tdata[2:0] != want.cls ||
              m_axis_tdata[12:3] != want.blk) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: status %0d/%0d class %0d/%0d block %0d/%0d (exp/got)",
                       want.status, m_axis_tuser, want.cls, m_axis_tdata[2:0],
                       want.blk, m_axis_tdata[12:3]);
          end
        end
      end
      backlog_o    <= outcome_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

>>> test/size_class_free_list_allocator_unit_tb.sv
// Testbench top for the size-class allocator: clock, reset, stimulus, watchdog and verdict.
module size_class_free_list_allocator_unit_tb;
  import scfa_pkg::*;

  // Receiver hold-off used once to back the block up into its input.
  localparam int unsigned PRESSURE_CYCLES = 300;
  // Cycles without any beat on any channel before the run is abandoned.
  // Slowest honest stretch is the hold-off plus a long gap, well below this.
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  // Quiet cycles after the last result.
  localparam int unsigned SETTLE_CYCLES   = 10;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_5 = 3'd5;
  // Indexes past the register file; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;   // request_size, block_handle, pad
  logic [1:0]           s_axis_tuser;   // kind, handle_present
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;   // class_index, block_index, pad
  logic [STATUS_W-1:0]  m_axis_tuser;   // status
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [SIZE_W-1:0]    cfg_data_i;

  int          backlog;          // results still owed by the block
  int          mismatches;
  int unsigned quiet_cycles = 0;
  bit          calm;             // no gaps on either side while set
  bit          hold_req;         // asks the receiver for one long hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  size_class_free_list_allocator_unit u_dut (.*);

  scfa_outcome_checker u_check (
    .*,
    .backlog_o    (backlog),
    .mismatches_o (mismatches)
  );

  // Mostly short idles, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One request beat. Entered and left at a falling edge; tvalid is left high
  // so back-to-back beats never see a drop and raise in one step.
  task automatic send_req(input logic kind, input logic [SIZE_W-1:0] size,
                          input logic present, input logic [BLK_W-1:0] handle);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, handle, size};
    s_axis_tuser  <= {present, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Random requests. Allocs and frees interleave so most frees land on a
  // class with blocks out, and popped handles carry random content.
  task automatic send_random(input int unsigned count, input int unsigned alloc_pct);
    logic              kind;
    logic [SIZE_W-1:0] size;
    int unsigned       pick;
    for (int unsigned n = 0; n < count; n++) begin
      kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
      pick = $urandom_range(0, 99);
      if (pick < 70)      size = SIZE_W'($urandom_range(0, 300));
      else if (pick < 85) size = SIZE_W'($urandom_range(0, 16));
      else                size = SIZE_W'($urandom());
      send_req(kind, size, $urandom_range(0, 9) != 0, BLK_W'($urandom_range(0, 1023)));
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (backlog != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register beat; valid stays up for a following write, end_writes drops it.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: ready toggles at random, with one long hold-off on request.
  initial begin
    int unsigned stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = PRESSURE_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 99) < 25) begin
        stall = idle_len();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("size_class_free_list_allocator_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset limits 8/16/32/64/128/256.
    send_req(KIND_ALLOC, 16'd0,     1'b0, 10'd0);     // smallest size, fresh top block
    send_req(KIND_ALLOC, 16'd8,     1'b0, 10'd0);     // exactly on class 0 limit
    send_req(KIND_ALLOC, 16'd9,     1'b0, 10'd0);     // just over, class 1
    send_req(KIND_ALLOC, 16'd256,   1'b0, 10'd0);     // top of last class
    send_req(KIND_ALLOC, 16'd257,   1'b0, 10'd0);     // too large
    send_req(KIND_ALLOC, 16'hFFFF,  1'b1, 10'h3FF);   // too large, largest size
    send_req(KIND_FREE,  16'hFFFF,  1'b0, 10'd0);     // oversize wins over null free
    send_req(KIND_FREE,  16'd4,     1'b0, 10'h3FF);   // null free ignored
    send_req(KIND_FREE,  16'd100,   1'b1, 10'd5);     // nothing out in class 4: overflow
    send_req(KIND_FREE,  16'd3,     1'b1, 10'h3FF);
    send_req(KIND_FREE,  16'd3,     1'b1, 10'h2AA);
    send_req(KIND_FREE,  16'd8,     1'b1, 10'h155);   // class 0 full again: overflow
    send_req(KIND_ALLOC, 16'd1,     1'b0, 10'd0);     // LIFO: last freed first
    send_req(KIND_ALLOC, 16'd1,     1'b0, 10'd0);
    send_req(KIND_ALLOC, 16'd0,     1'b0, 10'd0);     // list empty, back to fresh
    send_req(KIND_ALLOC, 16'd200,   1'b0, 10'd0);
    send_req(KIND_FREE,  16'd129,   1'b1, 10'd7);
    send_req(KIND_FREE,  16'd256,   1'b1, 10'd7);     // double free is pushed as given
    send_req(KIND_ALLOC, 16'd150,   1'b0, 10'd0);
    send_req(KIND_ALLOC, 16'd150,   1'b0, 10'd0);     // same handle handed out twice
    send_req(KIND_FREE,  16'd16,    1'b1, 10'h155);   // foreign handle into class 1
    send_req(KIND_ALLOC, 16'd10,    1'b0, 10'd0);
    send_req(KIND_FREE,  16'd9,     1'b1, 10'd0);
    finish_phase();

    // Random with reset limits; mid-way the receiver holds off for a long
    // stretch while requests keep coming, so the input side has to stall.
    send_random(150, 60);
    hold_req = 1'b1;
    send_random(200, 55);
    finish_phase();

    // Unsorted limits with both extremes, plus writes past the register file.
    write_limit(REG_LIMIT_0, 16'd1);
    write_limit(REG_LIMIT_1, SIZE_W'($urandom_range(100, 300)));
    write_limit(REG_LIMIT_2, 16'd4);
    write_limit(REG_LIMIT_3, SIZE_W'($urandom_range(1, 65535)));
    write_limit(REG_LIMIT_4, SIZE_W'($urandom_range(1, 65535)));
    write_limit(REG_LIMIT_5, 16'hFFFF);
    write_limit(REG_SPARE_6, SIZE_W'($urandom()));
    write_limit(REG_SPARE_7, SIZE_W'($urandom()));
    end_writes();
    calm = 1'b1;            // a stretch at full rate on both sides
    send_random(100, 50);
    calm = 1'b0;
    send_random(180, 45);
    finish_phase();

    // Every size lands in class 0; a long run of allocs drains it dry.
    write_limit(REG_LIMIT_0, 16'hFFFF);
    end_writes();
    send_random(1040, 100);
    send_random(60, 20);
    finish_phase();

    // Lowest limits everywhere: only sizes 0 and 1 fit anything.
    for (int ri = 0; ri < REG_COUNT; ri++) write_limit(CFG_IDX_W'(ri), 16'd1);
    end_writes();
    send_random(50, 50);
    finish_phase();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && backlog == 0) begin
      $display("size_class_free_list_allocator_unit_tb: clean");
    end else begin
      $display("size_class_free_list_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule
